[rtl/c_style_source_tokenizer_core_macros.svh]
// Assertion macros shared by the tokenizer checker.
// No dependencies.
`ifndef C_STYLE_SOURCE_TOKENIZER_CORE_MACROS_SVH
`define C_STYLE_SOURCE_TOKENIZER_CORE_MACROS_SVH
// Implication check, disabled during reset.
`define CST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication check, disabled during reset.
`define CST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

[rtl/cst_pkg.sv]
// Package for the C-style source tokenizer: widths, modes, kind codes, tables.
// No dependencies.
package cst_pkg;

    localparam int MAX_KEYWORD_LEN = 11;
    localparam int KIND_W = 7;
    localparam int MAX_RES = 4;
    localparam int CNT_W = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [9:0] {
        M_IDLE     = 10'b0000000001,
        M_COMMENT  = 10'b0000000010,
        M_STR      = 10'b0000000100,
        M_STR_ESC  = 10'b0000001000,
        M_FSTR     = 10'b0000010000,
        M_FSTR_ESC = 10'b0000100000,
        M_NUMBER   = 10'b0001000000,
        M_WORD     = 10'b0010000000,
        M_PEND_F   = 10'b0100000000,
        M_PEND_OP  = 10'b1000000000
    } t_mode;

    localparam logic [KIND_W-1:0] K_EOF = 7'd0;
    localparam logic [KIND_W-1:0] K_FSTR = 7'd1;
    localparam logic [KIND_W-1:0] K_STR = 7'd2;
    localparam logic [KIND_W-1:0] K_NUM = 7'd3;
    localparam logic [KIND_W-1:0] K_IDENT = 7'd4;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END = 1'b1;

    typedef struct packed {
        logic                has_byte;
        logic [7:0]          token_byte;
        logic                token_done;
        logic [KIND_W-1:0]   token_kind;
        logic                last;
    } t_res;

    // One classified input transaction: up to four results, plus count.
    typedef struct packed {
        logic [CNT_W-1:0]    count;
        t_res [MAX_RES-1:0]  res;
    } t_bundle;

    function automatic t_res mk_byte(input logic [7:0] b);
        t_res r;
        r = '0;
        r.has_byte = 1'b1;
        r.token_byte = b;
        return r;
    endfunction

    function automatic t_res mk_done(input logic [KIND_W-1:0] k);
        t_res r;
        r = '0;
        r.token_done = 1'b1;
        r.token_kind = k;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == 8'h5f;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        unique case (b)
            "(": k = 7'd55;
            ")": k = 7'd56;
            "{": k = 7'd57;
            "}": k = 7'd58;
            "[": k = 7'd59;
            "]": k = 7'd60;
            ";": k = 7'd61;
            ",": k = 7'd62;
            ".": k = 7'd63;
            "~": k = 7'd64;
            "@": k = 7'd65;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] alone_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            "+": k = 7'd33;
            "-": k = 7'd37;
            "*": k = 7'd39;
            "/": k = 7'd41;
            "%": k = 7'd43;
            "=": k = 7'd45;
            "!": k = 7'd47;
            "<": k = 7'd49;
            ">": k = 7'd51;
            "&": k = 7'd53;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] c,
                                                    input logic [7:0] n);
        logic [KIND_W-1:0] k;
        k = 7'd0;
        if (n == "=") begin
            unique case (c)
                "+": k = 7'd31;
                "-": k = 7'd34;
                "*": k = 7'd38;
                "/": k = 7'd40;
                "%": k = 7'd42;
                "=": k = 7'd44;
                "!": k = 7'd46;
                "<": k = 7'd48;
                ">": k = 7'd50;
                default: k = 7'd0;
            endcase
        end else if (c == "+" && n == "+") k = 7'd32;
        else if (c == "-" && n == "-") k = 7'd35;
        else if (c == "-" && n == ">") k = 7'd36;
        else if (c == "&" && n == "&") k = 7'd52;
        else if (c == "|" && n == "|") k = 7'd54;
        return k;
    endfunction

    // Keyword table: 27 spellings, left-aligned in 16 bytes.
    localparam int NKW = 27;
    typedef struct packed {
        logic [16*8-1:0] text;
        logic [4:0]      len;
        logic [KIND_W-1:0] kind;
    } t_kw;

    function automatic t_kw kw(input string s, input int k);
        t_kw e;
        e = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < s.len()) e.text[(15-i)*8 +: 8] = s[i];
        end
        e.len = 5'(s.len());
        e.kind = KIND_W'(k);
        return e;
    endfunction

    function automatic t_kw kw_entry(input int i);
        t_kw e;
        unique case (i)
            0: e = kw("int", 5);
            1: e = kw("string", 6);
            2: e = kw("float", 7);
            3: e = kw("double", 7);
            4: e = kw("bool", 8);
            5: e = kw("void", 9);
            6: e = kw("return", 10);
            7: e = kw("if", 11);
            8: e = kw("else", 12);
            9: e = kw("while", 13);
            10: e = kw("for", 14);
            11: e = kw("do", 15);
            12: e = kw("break", 16);
            13: e = kw("continue", 17);
            14: e = kw("true", 18);
            15: e = kw("false", 19);
            16: e = kw("cast", 20);
            17: e = kw({"static", "_cast"}, 21);
            18: e = kw("free", 22);
            19: e = kw("class", 23);
            20: e = kw("constructor", 24);
            21: e = kw("private", 25);
            22: e = kw("protected", 26);
            23: e = kw("global", 27);
            24: e = kw("self", 28);
            25: e = kw("struct", 29);
            26: e = kw("const", 30);
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

[rtl/cst_stream_if.sv]
// Valid/ready stream interfaces for the tokenizer channels.
// Depends on cst_pkg.
interface cst_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] text_byte;
    modport source (output valid, cmd, text_byte, input ready);
    modport sink (input valid, cmd, text_byte, output ready);
endinterface

interface cst_out_if;
    logic                       valid;
    logic                       ready;
    logic                       has_byte;
    logic [7:0]                 token_byte;
    logic                       token_done;
    logic [cst_pkg::KIND_W-1:0] token_kind;
    logic                       last;
    modport source (output valid, has_byte, token_byte, token_done, token_kind, last,
                    input ready);
    modport sink (input valid, has_byte, token_byte, token_done, token_kind, last,
                  output ready);
endinterface

[rtl/cst_front.sv]
// Front end: lexer state machine, turns one input transaction into a result bundle.
// Depends on cst_pkg.
module cst_front #(
    parameter int MaxKwLen = cst_pkg::MAX_KEYWORD_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_cmd,
    input  logic [7:0]       i_byte,
    output cst_pkg::t_bundle o_bundle
);
    localparam int LW = $clog2(MaxKwLen + 2);
    localparam int IW = $clog2(MaxKwLen);

    cst_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_held, n_held;
    logic           r_dot, n_dot;
    logic [LW-1:0]  r_len, n_len;
    logic [7:0]     r_buf [MaxKwLen];
    logic           wr_en;
    logic [IW-1:0]  wr_idx;
    logic [7:0]     wr_byte;

    // Keyword lookup over the current buffer; len of the word is given.
    function automatic logic [cst_pkg::KIND_W-1:0] word_kind(
        input logic [LW-1:0] len, input logic [7:0] bufv [MaxKwLen]);
        logic [cst_pkg::KIND_W-1:0] k;
        cst_pkg::t_kw e;
        logic ok;
        k = cst_pkg::K_IDENT;
        for (int i = 0; i < cst_pkg::NKW; i++) begin
            e = cst_pkg::kw_entry(i);
            ok = (32'(e.len) == 32'(len)) && (32'(len) <= MaxKwLen);
            for (int j = 0; j < MaxKwLen; j++) begin
                if (j < 16 && 32'(j) < 32'(len) && bufv[j] != e.text[(15-j)*8 +: 8])
                    ok = 1'b0;
                if (j >= 16 && 32'(j) < 32'(len)) ok = 1'b0;
            end
            if (ok && k == cst_pkg::K_IDENT) k = e.kind;
        end
        return k;
    endfunction

    always_comb begin
        cst_pkg::t_bundle bd;
        logic [cst_pkg::KIND_W-1:0] k;
        logic restart;
        logic [7:0] b;
        bd = '0;
        n_mode = r_mode;
        n_held = r_held;
        n_dot = r_dot;
        n_len = r_len;
        wr_en = 1'b0;
        wr_idx = '0;
        wr_byte = '0;
        restart = 1'b0;
        b = i_byte;
        if (i_cmd == cst_pkg::CMD_END) begin
            unique case (r_mode)
                cst_pkg::M_STR: begin
                    bd.res[bd.count[1:0]] = cst_pkg::mk_done(cst_pkg::K_STR);
                    bd.count++;
                end
                cst_pkg::M_FSTR: begin
                    bd.res[bd.count[1:0]] = cst_pkg::mk_done(cst_pkg::K_FSTR);
                    bd.count++;
                end
                cst_pkg::M_STR_ESC, cst_pkg::M_FSTR_ESC: begin
                    bd.res[0] = cst_pkg::mk_byte("\\");
                    bd.res[1] = cst_pkg::mk_done((r_mode == cst_pkg::M_FSTR_ESC) ?
                                                 cst_pkg::K_FSTR : cst_pkg::K_STR);
                    bd.count = 3'd2;
                end
                cst_pkg::M_NUMBER: begin
                    bd.res[0] = cst_pkg::mk_done(cst_pkg::K_NUM);
                    bd.count = 3'd1;
                end
                cst_pkg::M_WORD: begin
                    bd.res[0] = cst_pkg::mk_done(word_kind(r_len, r_buf));
                    bd.count = 3'd1;
                end
                cst_pkg::M_PEND_F: begin
                    bd.res[0] = cst_pkg::mk_byte("f");
                    bd.res[1] = cst_pkg::mk_done(cst_pkg::K_IDENT);
                    bd.count = 3'd2;
                end
                cst_pkg::M_PEND_OP: begin
                    k = cst_pkg::alone_kind(r_held);
                    if (k != '0) begin
                        bd.res[0] = cst_pkg::mk_byte(r_held);
                        bd.res[1] = cst_pkg::mk_done(k);
                        bd.count = 3'd2;
                    end
                end
                default: ;
            endcase
            bd.res[bd.count[1:0]] = cst_pkg::mk_done(cst_pkg::K_EOF);
            bd.count++;
            n_mode = cst_pkg::M_IDLE;
            n_held = '0;
            n_dot = 1'b0;
            n_len = '0;
        end else begin
            unique case (r_mode)
                cst_pkg::M_COMMENT: begin
                    if (b == 8'h0a) n_mode = cst_pkg::M_IDLE;
                end
                cst_pkg::M_STR, cst_pkg::M_FSTR: begin
                    if (b == "\"") begin
                        bd.res[0] = cst_pkg::mk_done((r_mode == cst_pkg::M_FSTR) ?
                                                     cst_pkg::K_FSTR : cst_pkg::K_STR);
                        bd.count = 3'd1;
                        n_mode = cst_pkg::M_IDLE;
                    end else if (b == "\\") begin
                        n_mode = (r_mode == cst_pkg::M_FSTR) ? cst_pkg::M_FSTR_ESC
                                                             : cst_pkg::M_STR_ESC;
                    end else begin
                        bd.res[0] = cst_pkg::mk_byte(b);
                        bd.count = 3'd1;
                    end
                end
                cst_pkg::M_STR_ESC, cst_pkg::M_FSTR_ESC: begin
                    bd.res[0] = cst_pkg::mk_byte((b == "n") ? 8'h0a :
                                                 (b == "t") ? 8'h09 : b);
                    bd.count = 3'd1;
                    n_mode = (r_mode == cst_pkg::M_FSTR_ESC) ? cst_pkg::M_FSTR
                                                             : cst_pkg::M_STR;
                end
                cst_pkg::M_NUMBER: begin
                    if (cst_pkg::is_digit(b) || (b == "." && !r_dot)) begin
                        if (b == ".") n_dot = 1'b1;
                        bd.res[0] = cst_pkg::mk_byte(b);
                        bd.count = 3'd1;
                    end else begin
                        bd.res[0] = cst_pkg::mk_done(cst_pkg::K_NUM);
                        bd.count = 3'd1;
                        restart = 1'b1;
                    end
                end
                cst_pkg::M_PEND_F: begin
                    if (b == "\"") begin
                        n_mode = cst_pkg::M_FSTR;
                    end else begin
                        // The held f becomes a one-letter word; a word byte joins it, any other byte closes it.
                        bd.res[0] = cst_pkg::mk_byte("f");
                        bd.count = 3'd1;
                        if (cst_pkg::is_word(b)) begin
                            bd.res[1] = cst_pkg::mk_byte(b);
                            bd.count = 3'd2;
                            // Only "f" is in the buffer; b is written at index 1.
                            wr_en = 1'b1;
                            wr_idx = IW'(1);
                            wr_byte = b;
                            n_len = LW'(2);
                            n_mode = cst_pkg::M_WORD;
                        end else begin
                            bd.res[1] = cst_pkg::mk_done(cst_pkg::K_IDENT);
                            bd.count = 3'd2;
                            restart = 1'b1;
                        end
                    end
                end
                cst_pkg::M_WORD: begin
                    if (cst_pkg::is_word(b)) begin
                        if (32'(r_len) < MaxKwLen) begin
                            wr_en = 1'b1;
                            wr_idx = r_len[IW-1:0];
                            wr_byte = b;
                        end
                        if (32'(r_len) <= MaxKwLen) n_len = r_len + LW'(1);
                        bd.res[0] = cst_pkg::mk_byte(b);
                        bd.count = 3'd1;
                    end else begin
                        bd.res[0] = cst_pkg::mk_done(word_kind(r_len, r_buf));
                        bd.count = 3'd1;
                        restart = 1'b1;
                    end
                end
                cst_pkg::M_PEND_OP: begin
                    if (r_held == "/" && b == "/") begin
                        n_mode = cst_pkg::M_COMMENT;
                    end else if (cst_pkg::pair_kind(r_held, b) != '0) begin
                        bd.res[0] = cst_pkg::mk_byte(r_held);
                        bd.res[1] = cst_pkg::mk_byte(b);
                        bd.res[2] = cst_pkg::mk_done(cst_pkg::pair_kind(r_held, b));
                        bd.count = 3'd3;
                        n_mode = cst_pkg::M_IDLE;
                    end else begin
                        k = cst_pkg::alone_kind(r_held);
                        if (k != '0) begin
                            bd.res[0] = cst_pkg::mk_byte(r_held);
                            bd.res[1] = cst_pkg::mk_done(k);
                            bd.count = 3'd2;
                        end
                        restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase
            if (restart) begin
                // Byte starts a new token from idle unless it is space or unknown, appended after any close results.
                n_mode = cst_pkg::M_IDLE;
                if (cst_pkg::is_space(b)) begin
                end else if (b == "f") begin
                    // The f is stored now in case it turns out to start a word.
                    n_mode = cst_pkg::M_PEND_F;
                    wr_en = 1'b1;
                    wr_idx = '0;
                    wr_byte = "f";
                end else if (b == "\"") begin
                    n_mode = cst_pkg::M_STR;
                end else if (cst_pkg::is_digit(b)) begin
                    n_mode = cst_pkg::M_NUMBER;
                    n_dot = 1'b0;
                    bd.res[bd.count[1:0]] = cst_pkg::mk_byte(b);
                    bd.count++;
                end else if (cst_pkg::is_alpha(b) || b == "_") begin
                    n_mode = cst_pkg::M_WORD;
                    wr_en = 1'b1;
                    wr_idx = '0;
                    wr_byte = b;
                    n_len = LW'(1);
                    bd.res[bd.count[1:0]] = cst_pkg::mk_byte(b);
                    bd.count++;
                end else if (cst_pkg::single_kind(b) != '0) begin
                    bd.res[bd.count[1:0]] = cst_pkg::mk_byte(b);
                    bd.count++;
                    bd.res[bd.count[1:0]] = cst_pkg::mk_done(cst_pkg::single_kind(b));
                    bd.count++;
                end else if (cst_pkg::alone_kind(b) != '0 || b == "|") begin
                    n_mode = cst_pkg::M_PEND_OP;
                    n_held = b;
                end
            end
        end
        if (bd.count != '0) bd.res[bd.count[1:0] - 2'd1].last = 1'b1;
        o_bundle = bd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cst_pkg::M_IDLE;
            r_held <= '0;
            r_dot <= 1'b0;
            r_len <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_dot <= n_dot;
            r_len <= n_len;
        end
    end

    // Word buffer: at most one byte is written per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) r_buf[wr_idx] <= wr_byte;
    end
endmodule

[rtl/cst_back.sv]
// Back end: bundle queue and serializer playing results out one per cycle while ready.
// Depends on cst_pkg.
module cst_back #(
    parameter int Depth = cst_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cst_pkg::t_bundle i_bundle,
    output logic             o_can_push,
    output logic             o_valid,
    output cst_pkg::t_res    o_res,
    input  logic             i_ready
);
    localparam int AW = $clog2(Depth);

    cst_pkg::t_bundle r_q [Depth];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic [1:0]       r_idx;
    logic             pop, pop_ent, push_ok;
    cst_pkg::t_bundle head;

    assign head = r_q[r_rp];
    assign push_ok = i_push && i_bundle.count != '0;
    assign o_valid = r_cnt != '0;
    assign o_res = head.res[r_idx];
    assign pop = o_valid && i_ready;
    assign pop_ent = pop && ({1'b0, r_idx} + 3'd1 == head.count);
    // Room is judged from the registered count only, so output ready never
    // reaches input ready in the same cycle.
    assign o_can_push = 32'(r_cnt) < Depth;

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (push_ok) r_wp <= (32'(r_wp) == Depth - 1) ? '0 : r_wp + AW'(1);
            if (pop_ent) begin
                r_rp <= (32'(r_rp) == Depth - 1) ? '0 : r_rp + AW'(1);
                r_idx <= '0;
            end else if (pop) begin
                r_idx <= r_idx + 2'd1;
            end
            r_cnt <= r_cnt + (AW+1)'(push_ok) - (AW+1)'(pop_ent);
        end
    end
endmodule

[rtl/c_style_source_tokenizer_core.sv]
// C-style source tokenizer: input byte stream to token text and kind stream.
// Depends on cst_pkg, cst_stream_if, cst_front and cst_back.
//
// Usage: s_in carries transactions of cmd and text_byte; cmd 0 delivers one
// source byte, cmd 1 marks end of source. m_out carries result transactions,
// one text byte (has_byte) or one token close (token_done with token_kind),
// with last set on the final result caused by an input transaction.
// An input transaction that causes no result produces nothing on m_out.
// The front end updates the lexer state in the cycle it accepts a transaction
// and writes up to four results as one bundle into a four-entry queue.
// The back end plays bundles out one result per cycle while m_out is ready;
// each bundle is registered in the queue before its first result appears. One
// input transaction is accepted per cycle while the queue has room; sustained
// throughput is one input per cycle until output bursts fill the queue, bounded
// by the one-result-per-cycle output port. When m_out stalls, results hold and
// the queue fills, and then s_in ready drops. Synchronous reset returns the lexer
// to idle between tokens and empties the queue; end of source returns it to idle.
module c_style_source_tokenizer_core #(
    parameter int MaxKwLen   = cst_pkg::MAX_KEYWORD_LEN,
    parameter int QueueDepth = cst_pkg::QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cst_in_if.sink  s_in,
    cst_out_if.source m_out
);
    cst_pkg::t_bundle bundle;
    cst_pkg::t_res    res;
    logic             can_push, fire;

    assign s_in.ready = can_push;
    assign fire = s_in.valid && can_push;

    cst_front #(.MaxKwLen(MaxKwLen)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire),
        .i_cmd(s_in.cmd), .i_byte(s_in.text_byte), .o_bundle(bundle)
    );

    cst_back #(.Depth(QueueDepth)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire), .i_bundle(bundle),
        .o_can_push(can_push), .o_valid(m_out.valid), .o_res(res),
        .i_ready(m_out.ready)
    );

    assign m_out.has_byte = res.has_byte;
    assign m_out.token_byte = res.token_byte;
    assign m_out.token_done = res.token_done;
    assign m_out.token_kind = res.token_kind;
    assign m_out.last = res.last;
endmodule

[rtl/cst_checker.sv]
// Port-level checker for the tokenizer, bound to the top level.
// Depends on cst_pkg and the macros header.
`include "c_style_source_tokenizer_core_macros.svh"
module cst_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_cmd,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       has_byte,
    input logic                       token_done,
    input logic [cst_pkg::KIND_W-1:0] token_kind,
    input logic                       last
);
    `CST_ASSERT_IMP(a_one_kind, i_clk, i_rst_n, out_valid, has_byte != token_done)
    `CST_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, out_valid && token_done, token_kind <= 7'd65)
    `CST_ASSERT_IMP(a_eof_last, i_clk, i_rst_n, out_valid && token_done && token_kind == 7'd0, last)
    `CST_ASSERT_NXT(a_end_out, i_clk, i_rst_n, in_valid && in_ready && in_cmd && !out_valid, out_valid)
    `CST_ASSERT_NXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
endmodule

bind c_style_source_tokenizer_core cst_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready), .in_cmd(s_in.cmd),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .has_byte(m_out.has_byte), .token_done(m_out.token_done),
    .token_kind(m_out.token_kind), .last(m_out.last)
);
